[hw/rtl/ccl_pkg.sv]
package ccl_pkg;

   localparam int CHAN_HDR_BYTES   = 8;
   localparam int ROUTER_HDR_BYTES = 4;
   localparam int VCHAN_HDR_BYTES  = 4;
   localparam int INNER_HDR_BYTES  = CHAN_HDR_BYTES - ROUTER_HDR_BYTES;
   localparam int ATTACH_MIN_BYTES = 6;

   localparam int DATA_SLOT_COUNT_DEF = 8;
   localparam int CTRL_SLOT_COUNT_DEF = 4;

   localparam int SLOT_LEN_W = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_NETDEV_TAG      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VCHAN_TAG       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TIMEOUT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_SLOT_BYTES = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CTRL_SLOT_BYTES = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_ENABLE     = 3'd5;

   localparam logic [2:0] KIND_START     = 3'd0;
   localparam logic [2:0] KIND_DATA      = 3'd1;
   localparam logic [2:0] KIND_DEV_RESET = 3'd2;
   localparam logic [2:0] KIND_DEV_STOP  = 3'd3;

   localparam logic [1:0] PORT_OK   = 2'd0;
   localparam logic [1:0] PORT_BUSY = 2'd1;

   typedef enum logic [1:0] {
      OP_UPLOAD  = 2'd0,
      OP_ENQUEUE = 2'd1,
      OP_SERVICE = 2'd2,
      OP_TICK    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      PH_RESET = 3'b001,
      PH_WAIT  = 3'b010,
      PH_RUN   = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_TOO_LONG = 3'd1,
      ST_FULL     = 3'd2,
      ST_STOPPED  = 3'd3,
      ST_BUSY     = 3'd4,
      ST_BAD_LEN  = 3'd5,
      ST_IGNORED  = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      ACT_NONE       = 4'd0,
      ACT_HOST_READY = 4'd1,
      ACT_SEND_SLOT  = 4'd2,
      ACT_DELIVER    = 4'd3,
      ACT_ATTACH     = 4'd4,
      ACT_CTRL_UP    = 4'd5,
      ACT_STARTED    = 4'd6,
      ACT_RESET      = 4'd7,
      ACT_DROPPED    = 4'd8
   } action_type;

   typedef struct packed {
      logic [7:0]  netdev_tag;
      logic [7:0]  vchan_tag;
      logic [15:0] start_timeout;
      logic [10:0] data_slot_bytes;
      logic [10:0] ctrl_slot_bytes;
      logic        link_enable;
   } cfg_type;

   typedef struct packed {
      opcode_type  opcode;
      logic        channel;
      logic [7:0]  tag;
      logic [2:0]  msg_kind;
      logic        credit_flag;
      logic [7:0]  credit_value;
      logic [11:0] upload_len;
      logic [15:0] router_len;
      logic [10:0] payload_len;
      logic [1:0]  port_result;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      action_type  action;
      logic        out_channel;
      logic [2:0]  slot_index;
      logic [11:0] length;
      logic [15:0] header_len_field;
      logic [7:0]  credit_now;
   } rsp_item_type;

endpackage

[hw/rtl/ccl_req_if.sv]
interface ccl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic        channel;
   logic [7:0]  tag;
   logic [2:0]  msg_kind;
   logic        credit_flag;
   logic [7:0]  credit_value;
   logic [11:0] upload_len;
   logic [15:0] router_len;
   logic [10:0] payload_len;
   logic [1:0]  port_result;

   modport source (
      output valid, opcode, channel, tag, msg_kind, credit_flag, credit_value,
             upload_len, router_len, payload_len, port_result,
      input  ready
   );
   modport sink (
      input  valid, opcode, channel, tag, msg_kind, credit_flag, credit_value,
             upload_len, router_len, payload_len, port_result,
      output ready
   );
endinterface

[hw/rtl/ccl_rsp_if.sv]
interface ccl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [3:0]  action;
   logic        out_channel;
   logic [2:0]  slot_index;
   logic [11:0] length;
   logic [15:0] header_len_field;
   logic [7:0]  credit_now;

   modport source (
      output valid, status, action, out_channel, slot_index, length,
             header_len_field, credit_now,
      input  ready
   );
   modport sink (
      input  valid, status, action, out_channel, slot_index, length,
             header_len_field, credit_now,
      output ready
   );
endinterface

[hw/rtl/ccl_slot_ram.sv]
module ccl_slot_ram #(
   parameter int DEPTH = 12,
   parameter int WIDTH = 11,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds between reads so a stalled stage keeps its value
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/ccl_ctx_unit.sv]
module ccl_ctx_unit #(
   parameter int DATA_SLOT_COUNT = ccl_pkg::DATA_SLOT_COUNT_DEF,
   parameter int CTRL_SLOT_COUNT = ccl_pkg::CTRL_SLOT_COUNT_DEF,
   localparam int AW = $clog2(DATA_SLOT_COUNT + CTRL_SLOT_COUNT)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  ccl_pkg::req_item_type           item,
   input  ccl_pkg::cfg_type                cfg,
   output ccl_pkg::rsp_item_type           result,
   output logic                            use_mem,
   output logic                            mem_we,
   output logic [AW-1:0]                   mem_waddr,
   output logic [ccl_pkg::SLOT_LEN_W-1:0]  mem_wdata,
   output logic                            mem_re,
   output logic [AW-1:0]                   mem_raddr
);

   import ccl_pkg::*;

   localparam int MAXS = (DATA_SLOT_COUNT > CTRL_SLOT_COUNT) ? DATA_SLOT_COUNT
                                                            : CTRL_SLOT_COUNT;
   localparam int IW = $clog2(MAXS);
   localparam int CW = $clog2(MAXS + 1);
   localparam logic [CW-1:0] DATA_N = CW'(DATA_SLOT_COUNT);
   localparam logic [CW-1:0] CTRL_N = CW'(CTRL_SLOT_COUNT);

   phase_type   phase_ff [2];
   phase_type   phase_in [2];
   logic [7:0]  credit_ff [2];
   logic [7:0]  credit_in [2];
   logic [7:0]  sent_ff [2];
   logic [7:0]  sent_in [2];
   logic [31:0] ready_time_ff [2];
   logic [31:0] ready_time_in [2];
   logic [IW-1:0] head_ff [2];
   logic [IW-1:0] head_in [2];
   logic [CW-1:0] count_ff [2];
   logic [CW-1:0] count_in [2];
   logic [31:0] tick_ff;
   logic [31:0] tick_in;

   logic        c;
   logic        uc;
   logic        tag_hit;
   logic        bad_len;
   logic [15:0] n_bytes;
   logic [CW-1:0] slots_c;
   logic [11:0] enq_len;
   logic [15:0] enq_hlen;
   logic [CW:0] tail_sum;
   logic [CW:0] tail_wrap;
   logic [IW-1:0] tail;
   logic [CW-1:0] head_inc;
   logic [IW-1:0] head_next;
   logic [31:0] elapsed;
   phase_type   phase_eff;
   logic [7:0]  avail;
   logic        can_send;
   logic        len_ok;
   logic        enq_ok;
   logic        pop;

   assign c       = item.channel;
   assign tag_hit = (item.tag == cfg.netdev_tag) || (item.tag == cfg.vchan_tag);
   assign uc      = (item.tag != cfg.netdev_tag);
   assign bad_len = (item.upload_len < 12'(CHAN_HDR_BYTES)) ||
                    (item.router_len < 16'(INNER_HDR_BYTES)) ||
                    ({1'b0, item.router_len} >
                     (17'(item.upload_len) - 17'(ROUTER_HDR_BYTES)));
   assign n_bytes = item.router_len - 16'(INNER_HDR_BYTES);

   assign slots_c  = c ? CTRL_N : DATA_N;
   assign enq_len  = 12'(CHAN_HDR_BYTES) + 12'(item.payload_len) +
                     (c ? 12'(VCHAN_HDR_BYTES) : 12'd0);
   assign enq_hlen = 16'(INNER_HDR_BYTES) + 16'(item.payload_len) +
                     (c ? 16'(VCHAN_HDR_BYTES) : 16'd0);
   assign tail_sum  = (CW+1)'(head_ff[c]) + (CW+1)'(count_ff[c]);
   assign tail_wrap = (tail_sum >= (CW+1)'(slots_c)) ? tail_sum - (CW+1)'(slots_c)
                                                     : tail_sum;
   assign tail      = tail_wrap[IW-1:0];
   assign head_inc  = CW'(head_ff[c]) + CW'(1);
   assign head_next = (head_inc == slots_c) ? '0 : head_inc[IW-1:0];

   assign elapsed   = tick_ff - ready_time_ff[c];
   assign phase_eff = (phase_ff[c] == PH_WAIT && elapsed > 32'(cfg.start_timeout))
                      ? PH_RESET : phase_ff[c];
   assign avail     = credit_ff[c] - sent_ff[c];
   assign can_send  = (phase_eff == PH_RUN) && (count_ff[c] != '0) &&
                      (avail != 8'd0) && !avail[7];

   assign len_ok = c ? (enq_len <= 12'(cfg.ctrl_slot_bytes))
                     : (enq_len <= 12'(cfg.data_slot_bytes));
   assign enq_ok = (item.opcode == OP_ENQUEUE) && cfg.link_enable && len_ok &&
                   (count_ff[c] < slots_c);
   assign pop    = (item.opcode == OP_SERVICE) && (phase_eff != PH_RESET) &&
                   can_send && (item.port_result != PORT_BUSY);

   assign mem_we    = accept && enq_ok;
   assign mem_waddr = c ? AW'(DATA_SLOT_COUNT) + AW'(tail) : AW'(tail);
   assign mem_wdata = enq_len[SLOT_LEN_W-1:0];
   assign mem_re    = accept && pop;
   assign mem_raddr = c ? AW'(DATA_SLOT_COUNT) + AW'(head_ff[c]) : AW'(head_ff[c]);
   assign use_mem   = pop;

   always_comb begin
      phase_in      = phase_ff;
      credit_in     = credit_ff;
      sent_in       = sent_ff;
      ready_time_in = ready_time_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      tick_in       = tick_ff;

      result                  = '0;
      result.status           = ST_OK;
      result.action           = ACT_NONE;
      result.out_channel      = c;
      result.credit_now       = credit_ff[c];

      unique case (item.opcode)
         OP_UPLOAD: begin
            if (bad_len) begin
               result.status      = ST_BAD_LEN;
               result.out_channel = 1'b0;
               result.credit_now  = 8'd0;
            end else if (!tag_hit) begin
               result.status      = ST_IGNORED;
               result.out_channel = 1'b0;
               result.credit_now  = 8'd0;
            end else begin
               result.out_channel = uc;
               if (item.msg_kind == KIND_START) begin
                  phase_in[uc]  = PH_RUN;
                  sent_in[uc]   = 8'd0;
                  credit_in[uc] = item.credit_flag ? item.credit_value : 8'd0;
                  result.credit_now = item.credit_flag ? item.credit_value : 8'd0;
                  if (uc) begin
                     result.action = ACT_CTRL_UP;
                  end else if (n_bytes >= 16'(ATTACH_MIN_BYTES)) begin
                     result.action = ACT_ATTACH;
                     result.length = n_bytes[11:0];
                  end else begin
                     result.action = ACT_STARTED;
                  end
               end else if (phase_ff[uc] != PH_RUN) begin
                  result.status     = ST_IGNORED;
                  result.credit_now = credit_ff[uc];
               end else begin
                  if (item.credit_flag) begin
                     credit_in[uc] = item.credit_value;
                  end
                  result.credit_now = item.credit_flag ? item.credit_value
                                                       : credit_ff[uc];
                  if (item.msg_kind == KIND_DATA) begin
                     result.action = ACT_DELIVER;
                     result.length = n_bytes[11:0];
                  end else if (item.msg_kind == KIND_DEV_RESET ||
                               item.msg_kind == KIND_DEV_STOP) begin
                     phase_in[uc]  = PH_RESET;
                     result.action = ACT_RESET;
                  end
               end
            end
         end
         OP_ENQUEUE: begin
            if (!cfg.link_enable) begin
               result.status = ST_STOPPED;
            end else if (!len_ok) begin
               result.status = ST_TOO_LONG;
            end else if (!enq_ok) begin
               result.status = ST_FULL;
            end else begin
               count_in[c]             = count_ff[c] + CW'(1);
               result.slot_index       = 3'(tail);
               result.length           = enq_len;
               result.header_len_field = enq_hlen;
            end
         end
         OP_SERVICE: begin
            phase_in[c] = phase_eff;
            if (phase_eff == PH_RESET) begin
               if (item.port_result == PORT_BUSY) begin
                  result.status = ST_BUSY;
               end else if (item.port_result == PORT_OK) begin
                  phase_in[c]             = PH_WAIT;
                  ready_time_in[c]        = tick_ff;
                  result.action           = ACT_HOST_READY;
                  result.length           = 12'(CHAN_HDR_BYTES);
                  result.header_len_field = 16'(INNER_HDR_BYTES);
               end
            end else if (can_send) begin
               result.slot_index = 3'(head_ff[c]);
               if (item.port_result == PORT_BUSY) begin
                  result.status = ST_BUSY;
               end else begin
                  head_in[c]  = head_next;
                  count_in[c] = count_ff[c] - CW'(1);
                  if (item.port_result == PORT_OK) begin
                     sent_in[c]    = sent_ff[c] + 8'd1;
                     result.action = ACT_SEND_SLOT;
                  end else begin
                     result.action = ACT_DROPPED;
                  end
               end
            end
         end
         OP_TICK: begin
            tick_in = tick_ff + 32'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            phase_ff[i]      <= PH_RESET;
            credit_ff[i]     <= '0;
            sent_ff[i]       <= '0;
            ready_time_ff[i] <= '0;
            head_ff[i]       <= '0;
            count_ff[i]      <= '0;
         end
         tick_ff <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         credit_ff     <= credit_in;
         sent_ff       <= sent_in;
         ready_time_ff <= ready_time_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         tick_ff       <= tick_in;
      end
   end

   a_ring_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff[0] <= DATA_N && count_ff[1] <= CTRL_N)
      else $error("ring fill beyond slot count");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      mem_re |=> count_ff[$past(c)] == $past(count_ff[c]) - CW'(1))
      else $error("slot read without ring pop");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> count_ff[$past(c)] == $past(count_ff[c]) + CW'(1))
      else $error("slot write without ring push");

endmodule

[hw/rtl/credit_channel_link_router_core.sv]
// Two register stages, stage one and the output register. One item is taken per
// cycle while the output is not held back by a low rsp.ready; channel context
// updates at the accept edge, the slot-length memory is read at that same edge
// and joins the result in the output register when stage one moves on. Reset
// (synchronous): channels to reset phase, counters and rings cleared, config
// registers to defaults, valids cleared; the slot-length memory is not cleared.
module credit_channel_link_router_core #(
   parameter int DATA_SLOT_COUNT = ccl_pkg::DATA_SLOT_COUNT_DEF,
   parameter int CTRL_SLOT_COUNT = ccl_pkg::CTRL_SLOT_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   ccl_req_if.sink                         req,
   ccl_rsp_if.source                       rsp,
   input  logic                            csr_we,
   input  logic [ccl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ccl_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import ccl_pkg::*;

   localparam int DEPTH = DATA_SLOT_COUNT + CTRL_SLOT_COUNT;
   localparam int AW    = $clog2(DEPTH);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   req_item_type  item;
   rsp_item_type  result;
   logic          accept;
   logic          use_mem;
   logic          mem_we;
   logic          mem_re;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;
   logic [SLOT_LEN_W-1:0] mem_wdata;
   logic [SLOT_LEN_W-1:0] mem_rdata;

   logic          s1_valid_ff;
   logic          s1_use_mem_ff;
   rsp_item_type  s1_item_ff;
   logic          s1_move;
   logic          rsp_valid_ff;
   rsp_item_type  rsp_item_ff;
   rsp_item_type  rsp_item_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_NETDEV_TAG:      cfg_in.netdev_tag      = csr_wdata[7:0];
            CSR_VCHAN_TAG:       cfg_in.vchan_tag       = csr_wdata[7:0];
            CSR_START_TIMEOUT:   cfg_in.start_timeout   = csr_wdata;
            CSR_DATA_SLOT_BYTES: cfg_in.data_slot_bytes = csr_wdata[10:0];
            CSR_CTRL_SLOT_BYTES: cfg_in.ctrl_slot_bytes = csr_wdata[10:0];
            CSR_LINK_ENABLE:     cfg_in.link_enable     = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.netdev_tag      <= 8'd5;
         cfg_ff.vchan_tag       <= 8'd13;
         cfg_ff.start_timeout   <= 16'd1000;
         cfg_ff.data_slot_bytes <= 11'd1536;
         cfg_ff.ctrl_slot_bytes <= 11'd128;
         cfg_ff.link_enable     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign item.opcode        = opcode_type'(req.opcode);
   assign item.channel       = req.channel;
   assign item.tag           = req.tag;
   assign item.msg_kind      = req.msg_kind;
   assign item.credit_flag   = req.credit_flag;
   assign item.credit_value  = req.credit_value;
   assign item.upload_len    = req.upload_len;
   assign item.router_len    = req.router_len;
   assign item.payload_len   = req.payload_len;
   assign item.port_result   = req.port_result;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_move;
   assign accept    = req.valid && req.ready;

   ccl_ctx_unit #(
      .DATA_SLOT_COUNT (DATA_SLOT_COUNT),
      .CTRL_SLOT_COUNT (CTRL_SLOT_COUNT)
   ) u_ctx (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (item),
      .cfg       (cfg_ff),
      .result    (result),
      .use_mem   (use_mem),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr)
   );

   ccl_slot_ram #(
      .DEPTH (DEPTH),
      .WIDTH (SLOT_LEN_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff    <= result;
         s1_use_mem_ff <= use_mem;
      end
   end

   // slot length of a popped transfer comes from the memory read
   always_comb begin
      rsp_item_in = s1_item_ff;
      if (s1_use_mem_ff) begin
         rsp_item_in.length = 12'(mem_rdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.status           = rsp_item_ff.status;
   assign rsp.action           = rsp_item_ff.action;
   assign rsp.out_channel      = rsp_item_ff.out_channel;
   assign rsp.slot_index       = rsp_item_ff.slot_index;
   assign rsp.length           = rsp_item_ff.length;
   assign rsp.header_len_field = rsp_item_ff.header_len_field;
   assign rsp.credit_now       = rsp_item_ff.credit_now;

   a_s1_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transfer lost before stage one");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_item_ff)
                                  && $stable(mem_rdata))
      else $error("stalled stage one changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_item_ff))
      else $error("stalled result changed");

endmodule
